// ===== design/tpps_pkg.sv =====
// tpps_pkg: shared types and constants of the sample-timer setting calculator
// no dependencies; imported by timer_prescaler_period_select
package tpps_pkg;

  // field and register widths
  localparam int unsigned CLK_W      = 32;
  localparam int unsigned SCALE_W    = 20;
  localparam int unsigned MINR_W     = 32;
  localparam int unsigned PERIOD_W   = 32;
  localparam int unsigned REQ_W      = 64;
  localparam int unsigned CODE_W     = 3;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned RATE_W     = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // internal datapath widths
  localparam int unsigned PROD_W    = CLK_W + SCALE_W;  // clock_hz * rate_scale
  localparam int unsigned TICK_W    = PROD_W;           // rounded tick count
  localparam int unsigned MUL_W     = 32;               // shared multiplier operand
  localparam int unsigned DIV_W     = 64;               // shared divider width
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);
  localparam int unsigned STEP_W    = 4;                // prescaler search step

  // register reset values
  localparam logic [CLK_W-1:0]    CLOCK_HZ_RST   = CLK_W'(100000000);
  localparam logic [SCALE_W-1:0]  RATE_SCALE_RST = SCALE_W'(1000);
  localparam logic [MINR_W-1:0]   MIN_RATE_RST   = MINR_W'(1000);
  localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST = PERIOD_W'(65535);

  // prescaler search constants
  localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(8);  // divide by 256
  localparam logic [STEP_W-1:0] STEP_HALVE = STEP_W'(7);  // divide by 128, not available
  localparam logic [CODE_W-1:0] CODE_DIV256 = CODE_W'(7);
  localparam logic [STEP_W-1:0] SLOW_SHIFT  = STEP_W'(8);
  localparam logic [TICK_W-1:0] SLOW_ROUND  = TICK_W'(128);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOCK_HZ       = 2'd0,
    REG_RATE_SCALE     = 2'd1,
    REG_MIN_TIMER_RATE = 2'd2,
    REG_MAX_PERIOD     = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_P,
    S_MUL_T,
    S_DIV_TICK,
    S_MODE,
    S_DIV_CNT,
    S_CNT_CHK,
    S_CNT_LD,
    S_DIV_TICK2,
    S_TICK2_CHK,
    S_FIT,
    S_HALF,
    S_RATE_MUL,
    S_RATE_LD,
    S_DIV_RATE,
    S_OUT
  } tpps_state_e;

endpackage

// ===== design/timer_prescaler_period_select.sv =====
// timer_prescaler_period_select: sample-timer period, prescaler and outer count
// from a requested rate; one shared multiplier and one radix-2 divider
// depends on tpps_pkg
//
// Usage: write clock_hz, rate_scale, min_timer_rate and max_period through the
// cfg port (cfg_we_i, cfg_idx_i, cfg_data_i) while the block is idle. Send a
// requested rate as one beat on the input channel; in_stall_o stays high from
// the accepting edge until the result beat has been taken. The result holds
// on the output channel, stable, for as long as out_stall_i is high.
// The restoring divider retires one quotient bit per cycle. Fast requests use
// two divisions plus one to nine prescaler search steps; slow requests use four
// divisions. A zero request or an unusable setting ends early with the error
// flag set. One item is in flight at a time; the next is accepted the cycle
// after the result beat. Reset puts the registers at 100 MHz, scale 1000, min
// rate 1000, max period 65535 and returns the sequencer to idle.
module timer_prescaler_period_select (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tpps_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tpps_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tpps_pkg::REQ_W-1:0]        requested_rate_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [tpps_pkg::PERIOD_W-1:0]     timer_period_o,
  output logic [tpps_pkg::CODE_W-1:0]       prescale_code_o,
  output logic [tpps_pkg::CNT_W-1:0]        outer_count_o,
  output logic [tpps_pkg::RATE_W-1:0]       actual_rate_o,
  output logic                              error_o
);
  import tpps_pkg::*;

  tpps_state_e state_q, state_d;

  logic [CLK_W-1:0]    clock_hz_q;
  logic [SCALE_W-1:0]  rate_scale_q;
  logic [MINR_W-1:0]   min_rate_q;
  logic [PERIOD_W-1:0] max_period_q;

  logic [REQ_W-1:0]    req_q;
  logic [PROD_W-1:0]   prod_q;
  logic [PROD_W-1:0]   thr_q;
  logic [DIV_W-1:0]    denom_q;
  logic [TICK_W-1:0]   tick_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [CODE_W-1:0]   code_q;
  logic [STEP_W-1:0]   step_q;
  logic [STEP_W-1:0]   shift_q;
  logic                err_q;

  // shared divider
  logic [DIV_W-1:0]     div_n_q, div_d_q, div_r_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [DIV_W:0]       div_rsh;
  logic [DIV_W+1:0]     div_diff;
  logic                 div_ge;
  logic                 div_last;
  logic                 div_run;
  logic                 div_ld;
  logic [DIV_W-1:0]     div_ld_n, div_ld_d;

  // shared multiplier
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [2*MUL_W-1:0]   mul_res;

  // decision terms
  logic                 req_zero;
  logic                 slow;
  logic                 mp_zero;
  logic [TICK_W-1:0]    slow_tick;
  logic [DIV_W-1:0]     cnt_full;
  logic                 cnt_ovf;
  logic [CNT_W-1:0]     cnt_val;
  logic                 quot_zero;
  logic [TICK_W:0]      fit_half;
  logic [TICK_W:0]      fit_t;
  logic                 fit_ok;
  logic                 fit_zero;
  logic                 fail;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q   <= CLOCK_HZ_RST;
      rate_scale_q <= RATE_SCALE_RST;
      min_rate_q   <= MIN_RATE_RST;
      max_period_q <= MAX_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_CLOCK_HZ:       clock_hz_q   <= cfg_data_i[CLK_W-1:0];
        REG_RATE_SCALE:     rate_scale_q <= cfg_data_i[SCALE_W-1:0];
        REG_MIN_TIMER_RATE: min_rate_q   <= cfg_data_i[MINR_W-1:0];
        REG_MAX_PERIOD:     max_period_q <= cfg_data_i[PERIOD_W-1:0];
      endcase
    end
  end

  // datapath terms
  always_comb begin
    div_rsh  = {div_r_q, div_n_q[DIV_W-1]};
    div_diff = {1'b0, div_rsh} - {2'b00, div_d_q};
    div_ge   = ~div_diff[DIV_W+1];
    div_last = (div_cnt_q == DIV_CNT_W'(DIV_W - 1));

    case (state_q)
      S_MUL_P: begin
        mul_a = clock_hz_q;
        mul_b = MUL_W'(rate_scale_q);
      end
      S_MUL_T: begin
        mul_a = min_rate_q;
        mul_b = MUL_W'(rate_scale_q);
      end
      default: begin
        mul_a = tick_q[MUL_W-1:0];
        mul_b = cnt_q;
      end
    endcase
    mul_res = mul_a * mul_b;

    req_zero  = (req_q == '0);
    slow      = (req_q < REQ_W'(thr_q));
    mp_zero   = (max_period_q == '0);
    slow_tick = (div_n_q[TICK_W-1:0] + SLOW_ROUND) >> SLOW_SHIFT;

    // ceiling of tick / max_period, at least one
    cnt_full  = div_n_q + DIV_W'(div_r_q != '0);
    cnt_ovf   = (cnt_full[DIV_W-1:CNT_W] != '0);
    cnt_val   = (cnt_full == '0) ? CNT_W'(1) : cnt_full[CNT_W-1:0];
    quot_zero = (div_n_q == '0);

    // rounded tick / 2^step
    fit_half  = ((TICK_W+1)'(1) << step_q) >> 1;
    fit_t     = ({1'b0, tick_q} + fit_half) >> step_q;
    fit_ok    = (fit_t <= (TICK_W+1)'(max_period_q));
    fit_zero  = (fit_t == '0);

    div_ld   = 1'b0;
    div_ld_n = '0;
    div_ld_d = '0;
    fail     = 1'b0;
    case (state_q)
      S_MUL_T: begin
        fail     = req_zero;
        div_ld   = ~req_zero;
        div_ld_n = DIV_W'(prod_q) + (req_q >> 1);
        div_ld_d = req_q;
      end
      S_MODE: begin
        fail     = slow & mp_zero;
        div_ld   = slow & ~mp_zero;
        div_ld_n = DIV_W'(slow_tick);
        div_ld_d = DIV_W'(max_period_q);
      end
      S_CNT_CHK: fail = cnt_ovf;
      S_CNT_LD: begin
        div_ld   = 1'b1;
        div_ld_n = DIV_W'(tick_q) + DIV_W'(cnt_q >> 1);
        div_ld_d = DIV_W'(cnt_q);
      end
      S_TICK2_CHK: fail = quot_zero;
      S_FIT: fail = fit_ok ? fit_zero : (step_q == STEP_LAST);
      S_RATE_LD: begin
        div_ld   = 1'b1;
        div_ld_n = DIV_W'(prod_q >> shift_q) + (denom_q >> 1);
        div_ld_d = denom_q;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (in_valid_i) state_d = S_MUL_P;
      S_MUL_P:     state_d = S_MUL_T;
      S_MUL_T:     state_d = req_zero ? S_OUT : S_DIV_TICK;
      S_DIV_TICK:  if (div_last) state_d = S_MODE;
      S_MODE: begin
        if (slow) state_d = mp_zero ? S_OUT : S_DIV_CNT;
        else      state_d = S_FIT;
      end
      S_DIV_CNT:   if (div_last) state_d = S_CNT_CHK;
      S_CNT_CHK:   state_d = cnt_ovf ? S_OUT : S_CNT_LD;
      S_CNT_LD:    state_d = S_DIV_TICK2;
      S_DIV_TICK2: if (div_last) state_d = S_TICK2_CHK;
      S_TICK2_CHK: state_d = quot_zero ? S_OUT : S_RATE_MUL;
      S_FIT: begin
        if (fit_ok) begin
          if (fit_zero)                  state_d = S_OUT;
          else if (step_q == STEP_HALVE) state_d = S_HALF;
          else                           state_d = S_RATE_MUL;
        end else if (step_q == STEP_LAST) begin
          state_d = S_OUT;
        end
      end
      S_HALF:      state_d = S_RATE_MUL;
      S_RATE_MUL:  state_d = S_RATE_LD;
      S_RATE_LD:   state_d = S_DIV_RATE;
      S_DIV_RATE:  if (div_last) state_d = S_OUT;
      S_OUT:       if (!out_stall_i) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // handshake and result fields
  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    out_valid_o = (state_q == S_OUT);
    div_run     = (state_q == S_DIV_TICK) || (state_q == S_DIV_CNT) ||
                  (state_q == S_DIV_TICK2) || (state_q == S_DIV_RATE);
    timer_period_o  = err_q ? PERIOD_W'(1) : tick_q[PERIOD_W-1:0];
    prescale_code_o = err_q ? '0 : code_q;
    outer_count_o   = err_q ? CNT_W'(1) : cnt_q;
    actual_rate_o   = err_q ? '0 : div_n_q;
    error_o         = err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      err_q     <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && in_valid_i) begin
        err_q <= 1'b0;
      end else if (fail) begin
        err_q <= 1'b1;
      end
      if (div_ld) begin
        div_cnt_q <= '0;
      end else if (div_run) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (div_ld) begin
      div_n_q <= div_ld_n;
      div_d_q <= div_ld_d;
      div_r_q <= '0;
    end else if (div_run) begin
      div_r_q <= div_ge ? div_diff[DIV_W-1:0] : div_rsh[DIV_W-1:0];
      div_n_q <= {div_n_q[DIV_W-2:0], div_ge};
    end

    case (state_q)
      S_IDLE:     if (in_valid_i) req_q <= requested_rate_i;
      S_MUL_P:    prod_q <= mul_res[PROD_W-1:0];
      S_MUL_T:    thr_q  <= mul_res[PROD_W-1:0];
      S_MODE: begin
        if (slow) begin
          tick_q <= slow_tick;
        end else begin
          tick_q <= div_n_q[TICK_W-1:0];
          cnt_q  <= CNT_W'(1);
          step_q <= '0;
        end
      end
      S_CNT_CHK:  cnt_q <= cnt_val;
      S_TICK2_CHK: begin
        tick_q  <= div_n_q[TICK_W-1:0];
        code_q  <= CODE_DIV256;
        shift_q <= SLOW_SHIFT;
      end
      S_FIT: begin
        if (fit_ok) begin
          tick_q  <= fit_t[TICK_W-1:0];
          shift_q <= step_q;
          code_q  <= (step_q >= STEP_HALVE) ? CODE_DIV256 : step_q[CODE_W-1:0];
        end else begin
          step_q <= step_q + STEP_W'(1);
        end
      end
      S_HALF: begin
        // no divide by 128: halve the period and use 256
        tick_q  <= (tick_q + TICK_W'(1)) >> 1;
        shift_q <= STEP_LAST;
      end
      S_RATE_MUL: denom_q <= DIV_W'(mul_res);
      default: ;
    endcase
  end

endmodule
